[src/dtbp_pkg.sv]
// Shared types and constants for the devicetree blob token parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtbp_pkg;

  localparam int OFFSET_BITS_DEF = 20;

  localparam logic [31:0] DT_MAGIC = 32'hD00D_FEED;

  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_NOP        = 32'd4;
  localparam logic [31:0] TOK_END        = 32'd9;

  // Header words holding the structure and strings block offsets
  localparam int HDR_STRUCT_WORD  = 2;
  localparam int HDR_STRINGS_WORD = 3;
  // Smallest legal structure block offset (end of the fixed header words)
  localparam int MIN_STRUCT_OFF   = 16;

  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_HDR_OK   = 4'd1,
    EV_BAD_MAGIC = 4'd2,
    EV_BEGIN    = 4'd3,
    EV_PROP     = 4'd4,
    EV_END_NODE = 4'd5,
    EV_END      = 4'd6,
    EV_UNKNOWN  = 4'd7,
    EV_RANGE    = 4'd8
  } event_t;

endpackage

`default_nettype wire

[src/dtbp_in_if.sv]
// Input channel: one blob word per beat, valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface dtbp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] blob_word;
  logic        first_word;

  modport source (output valid, output blob_word, output first_word, input ready);
  modport sink   (input valid, input blob_word, input first_word, output ready);
endinterface

`default_nettype wire

[src/dtbp_out_if.sv]
// Result channel: one event per beat, valid/ready handshake.
// Depends on dtbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dtbp_out_if
  import dtbp_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             event_res;
  logic [OFFSET_BITS-1:0] node_offset;
  logic [OFFSET_BITS-1:0] prop_name_offset;
  logic [OFFSET_BITS-1:0] value_offset;
  logic [OFFSET_BITS-1:0] value_length;

  modport source (output valid, output event_res, output node_offset,
                  output prop_name_offset, output value_offset,
                  output value_length, input ready);
  modport sink   (input valid, input event_res, input node_offset,
                  input prop_name_offset, input value_offset,
                  input value_length, output ready);
endinterface

`default_nettype wire

[src/devicetree_blob_token_parser.sv]
// Top level of the devicetree blob token parser: input register, decode core,
// result register. Depends on dtbp_pkg, dtbp_in_if, dtbp_out_if, dtbp_core.
//
//   channel  direction  payload                                   beat
//   in_ch    sink       blob_word[31:0], first_word               one blob word
//   out_ch   source     event_res, node/prop name/value offsets,  one event
//                       value_length
//
// One word per cycle sustained while out_ch is not stalled; every accepted word yields
// exactly one result beat.
// Each word passes from the input register through the decode core into the
// result register; the parser state updates in the same cycle.
// Reset (rst_n low, synchronous) leaves the parser idle until a first word.
// A stall on out_ch holds both registers; in_ch.ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module devicetree_blob_token_parser
  import dtbp_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dtbp_in_if.sink     in_ch,
  dtbp_out_if.source  out_ch
);

  logic                   in_valid_r;
  logic [31:0]            word_r;
  logic                   first_r;
  logic                   out_valid_r;
  event_t                 event_r;
  logic [OFFSET_BITS-1:0] node_r, pname_r, valo_r, vlen_r;

  logic                   adv;
  logic                   in_rdy;
  logic                   step;
  event_t                 ev_nxt;
  logic [OFFSET_BITS-1:0] node_nxt, pname_nxt, valo_nxt, vlen_nxt;

  assign adv    = !out_valid_r || out_ch.ready;
  assign in_rdy = !in_valid_r || adv;
  assign step   = in_valid_r && adv;

  dtbp_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (word_r),
    .first     (first_r),
    .ev_nxt    (ev_nxt),
    .node_nxt  (node_nxt),
    .pname_nxt (pname_nxt),
    .valo_nxt  (valo_nxt),
    .vlen_nxt  (vlen_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_valid_r <= in_ch.valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      word_r  <= in_ch.blob_word;
      first_r <= in_ch.first_word;
    end
    if (step) begin
      event_r <= ev_nxt;
      node_r  <= node_nxt;
      pname_r <= pname_nxt;
      valo_r  <= valo_nxt;
      vlen_r  <= vlen_nxt;
    end
  end

  assign in_ch.ready             = in_rdy;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.event_res        = event_r;
  assign out_ch.node_offset      = node_r;
  assign out_ch.prop_name_offset = pname_r;
  assign out_ch.value_offset     = valo_r;
  assign out_ch.value_length     = vlen_r;

endmodule

`default_nettype wire

[src/dtbp_core.sv]
// Parser state and per-word decode: header walk, token decode, name and value skip.
// Depends on dtbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtbp_core
  import dtbp_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [31:0]            word,
  input  wire logic                   first,
  output event_t                      ev_nxt,
  output logic [OFFSET_BITS-1:0]      node_nxt,
  output logic [OFFSET_BITS-1:0]      pname_nxt,
  output logic [OFFSET_BITS-1:0]      valo_nxt,
  output logic [OFFSET_BITS-1:0]      vlen_nxt
);

  localparam int WI_W = OFFSET_BITS - 2;
  localparam int SK_W = OFFSET_BITS - 1;

  typedef enum logic [2:0] {
    PH_DONE, PH_HEADER, PH_TOKEN, PH_NAME, PH_PLEN, PH_PNAME, PH_SKIP
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [WI_W-1:0]        word_index_r, word_index_nxt;
  logic [31:0]            struct_start_r, struct_start_nxt;
  logic [OFFSET_BITS-1:0] strings_start_r, strings_start_nxt;
  logic [OFFSET_BITS-1:0] current_node_r, current_node_nxt;
  logic [31:0]            pending_length_r, pending_length_nxt;
  logic [SK_W-1:0]        words_to_skip_r, words_to_skip_nxt;

  logic [OFFSET_BITS:0]   voff;
  logic [32:0]            nsum;
  logic [32:0]            skip_sum;
  logic                   zero_byte;
  logic                   name_bad;
  logic                   len_bad;
  logic                   struct_bad;
  logic                   strings_bad;

  always_comb begin
    voff        = {1'b0, word_index_r, 2'b00} + (OFFSET_BITS+1)'(4);
    nsum        = {1'b0, 32'(strings_start_r)} + {1'b0, word};
    skip_sum    = {1'b0, pending_length_r} + 33'd3;
    zero_byte   = (word[31:24] == 8'd0) || (word[23:16] == 8'd0) ||
                  (word[15:8] == 8'd0) || (word[7:0] == 8'd0);
    name_bad    = (nsum >> OFFSET_BITS) != 33'd0;
    // value may end exactly at the top of the offset space
    len_bad     = (34'(pending_length_r) + 34'(voff)) > (34'd1 << OFFSET_BITS);
    struct_bad  = ((struct_start_r >> OFFSET_BITS) != 32'd0) ||
                  (struct_start_r < 32'(MIN_STRUCT_OFF));
    strings_bad = (word >> OFFSET_BITS) != 32'd0;
  end

  always_comb begin
    phase_nxt          = phase_r;
    word_index_nxt     = word_index_r;
    struct_start_nxt   = struct_start_r;
    strings_start_nxt  = strings_start_r;
    current_node_nxt   = current_node_r;
    pending_length_nxt = pending_length_r;
    words_to_skip_nxt  = words_to_skip_r;
    ev_nxt             = EV_NONE;
    node_nxt           = '0;
    pname_nxt          = '0;
    valo_nxt           = '0;
    vlen_nxt           = '0;

    if (first) begin
      word_index_nxt     = '0;
      struct_start_nxt   = '0;
      strings_start_nxt  = '0;
      current_node_nxt   = '0;
      pending_length_nxt = '0;
      words_to_skip_nxt  = '0;
      if (word == DT_MAGIC) begin
        ev_nxt    = EV_HDR_OK;
        phase_nxt = PH_HEADER;
      end else begin
        ev_nxt    = EV_BAD_MAGIC;
        phase_nxt = PH_DONE;
      end
    end else if (phase_r != PH_DONE) begin
      case (phase_r)
        PH_HEADER: begin
          if (word_index_r == WI_W'(HDR_STRUCT_WORD)) begin
            struct_start_nxt = {word[31:2], 2'b00};
          end else if (word_index_r == WI_W'(HDR_STRINGS_WORD)) begin
            strings_start_nxt = word[OFFSET_BITS-1:0];
            if (struct_bad || strings_bad) begin
              ev_nxt    = EV_RANGE;
              phase_nxt = PH_DONE;
            end else if (struct_start_r == 32'(MIN_STRUCT_OFF)) begin
              phase_nxt = PH_TOKEN;
            end
          end else if (word_index_r > WI_W'(HDR_STRINGS_WORD) &&
                       (32'(word_index_r) + 32'd1) == {2'b00, struct_start_r[31:2]}) begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          case (word)
            TOK_BEGIN_NODE: begin
              current_node_nxt = voff[OFFSET_BITS-1:0];
              ev_nxt           = EV_BEGIN;
              node_nxt         = voff[OFFSET_BITS-1:0];
              phase_nxt        = PH_NAME;
            end
            TOK_PROP:     phase_nxt = PH_PLEN;
            TOK_NOP:      phase_nxt = PH_TOKEN;
            TOK_END_NODE: ev_nxt = EV_END_NODE;
            TOK_END: begin
              ev_nxt    = EV_END;
              phase_nxt = PH_DONE;
            end
            default: begin
              ev_nxt    = EV_UNKNOWN;
              phase_nxt = PH_DONE;
            end
          endcase
        end
        PH_NAME: begin
          if (zero_byte) begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_PLEN: begin
          pending_length_nxt = word;
          phase_nxt          = PH_PNAME;
        end
        PH_PNAME: begin
          if (name_bad || len_bad) begin
            ev_nxt    = EV_RANGE;
            phase_nxt = PH_DONE;
          end else begin
            ev_nxt            = EV_PROP;
            node_nxt          = current_node_r;
            pname_nxt         = nsum[OFFSET_BITS-1:0];
            valo_nxt          = voff[OFFSET_BITS-1:0];
            vlen_nxt          = pending_length_r[OFFSET_BITS-1:0];
            words_to_skip_nxt = skip_sum[OFFSET_BITS:2];
            phase_nxt         = (skip_sum[OFFSET_BITS:2] == '0) ? PH_TOKEN : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (words_to_skip_r != '0) begin
            words_to_skip_nxt = words_to_skip_r - SK_W'(1);
          end
          if (words_to_skip_r <= SK_W'(1)) begin
            phase_nxt = PH_TOKEN;
          end
        end
        default: phase_nxt = PH_DONE;
      endcase

      // last addressable word reached with parsing still open
      if (word_index_r == '1 && phase_nxt != PH_DONE) begin
        ev_nxt    = EV_RANGE;
        phase_nxt = PH_DONE;
        node_nxt  = '0;
        pname_nxt = '0;
        valo_nxt  = '0;
        vlen_nxt  = '0;
      end
    end

    if (phase_nxt != PH_DONE) begin
      word_index_nxt = word_index_nxt + WI_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_DONE;
      word_index_r     <= '0;
      struct_start_r   <= '0;
      strings_start_r  <= '0;
      current_node_r   <= '0;
      pending_length_r <= '0;
      words_to_skip_r  <= '0;
    end else if (step) begin
      phase_r          <= phase_nxt;
      word_index_r     <= word_index_nxt;
      struct_start_r   <= struct_start_nxt;
      strings_start_r  <= strings_start_nxt;
      current_node_r   <= current_node_nxt;
      pending_length_r <= pending_length_nxt;
      words_to_skip_r  <= words_to_skip_nxt;
    end
  end

endmodule

`default_nettype wire

[tb/tb_devicetree_blob_token_parser.sv]
// Self-checking bench for devicetree_blob_token_parser: directed and random blobs,
// with an event-decode scoreboard and random stalls on both channels.
// Depends on dtbp_pkg, dtbp_in_if, dtbp_out_if and the parser RTL.
`timescale 1ns / 1ps

module tb_devicetree_blob_token_parser
  import dtbp_pkg::*;
;

  localparam int              OFB         = OFFSET_BITS_DEF;
  localparam int              IDX_BITS    = OFB - 2;
  localparam longint unsigned SPACE       = 64'd1 << OFB;
  localparam longint unsigned MAX_WORD    = (SPACE >> 2) - 1;
  localparam int              STALL_LIMIT = 2000;
  localparam int              RAND_WORDS  = 1550;

  typedef enum logic [2:0] {
    PH_DONE, PH_HEADER, PH_TOKEN, PH_NAME, PH_PLEN, PH_PNAME, PH_SKIP
  } parse_phase_t;

  typedef struct packed {
    event_t         ev;
    logic [OFB-1:0] node;
    logic [OFB-1:0] pname;
    logic [OFB-1:0] voff;
    logic [OFB-1:0] vlen;
  } dt_event_t;

  // Tracks the parser state and holds the events still owed by the block
  class dt_event_scoreboard;
    parse_phase_t        phase;
    bit [IDX_BITS-1:0]   word_idx;
    longint unsigned     struct_off, strings_off, node_off, prop_len, skip_words;
    dt_event_t           expected_q[$];
    int                  mismatches;
    int                  beat_no;

    function new();
      phase       = PH_DONE;
      word_idx    = '0;
      struct_off  = 0;
      strings_off = 0;
      node_off    = 0;
      prop_len    = 0;
      skip_words  = 0;
      mismatches  = 0;
      beat_no     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function dt_event_t decode_word(bit [31:0] w, bit first);
      dt_event_t       r;
      longint unsigned pos, name_sum, val_off;
      r    = '0;
      r.ev = EV_NONE;
      if (first) begin
        word_idx    = '0;
        struct_off  = 0;
        strings_off = 0;
        node_off    = 0;
        prop_len    = 0;
        skip_words  = 0;
        if (w == DT_MAGIC) begin
          r.ev  = EV_HDR_OK;
          phase = PH_HEADER;
        end else begin
          r.ev  = EV_BAD_MAGIC;
          phase = PH_DONE;
        end
      end else if (phase != PH_DONE) begin
        pos = 64'(word_idx) << 2;
        case (phase)
          PH_HEADER: begin
            if (word_idx == HDR_STRUCT_WORD) begin
              struct_off = w & ~32'h3;
            end else if (word_idx == HDR_STRINGS_WORD) begin
              strings_off = w;
              if (struct_off >= SPACE || strings_off >= SPACE ||
                  struct_off < MIN_STRUCT_OFF) begin
                r.ev  = EV_RANGE;
                phase = PH_DONE;
              end else if (struct_off == MIN_STRUCT_OFF) begin
                phase = PH_TOKEN;
              end
            end else if (word_idx > HDR_STRINGS_WORD &&
                         64'(word_idx) + 1 == (struct_off >> 2)) begin
              phase = PH_TOKEN;
            end
          end
          PH_TOKEN: begin
            case (w)
              TOK_BEGIN_NODE: begin
                node_off = pos + 4;
                r.ev     = EV_BEGIN;
                r.node   = node_off[OFB-1:0];
                phase    = PH_NAME;
              end
              TOK_PROP:     phase = PH_PLEN;
              TOK_NOP:      ;
              TOK_END_NODE: r.ev = EV_END_NODE;
              TOK_END: begin
                r.ev  = EV_END;
                phase = PH_DONE;
              end
              default: begin
                r.ev  = EV_UNKNOWN;
                phase = PH_DONE;
              end
            endcase
          end
          PH_NAME: begin
            if (w[31:24] == 0 || w[23:16] == 0 || w[15:8] == 0 || w[7:0] == 0)
              phase = PH_TOKEN;
          end
          PH_PLEN: begin
            prop_len = w;
            phase    = PH_PNAME;
          end
          PH_PNAME: begin
            name_sum = strings_off + w;
            val_off  = pos + 4;
            if (name_sum >= SPACE || prop_len > SPACE - val_off) begin
              r.ev  = EV_RANGE;
              phase = PH_DONE;
            end else begin
              r.ev       = EV_PROP;
              r.node     = node_off[OFB-1:0];
              r.pname    = name_sum[OFB-1:0];
              r.voff     = val_off[OFB-1:0];
              r.vlen     = prop_len[OFB-1:0];
              skip_words = (prop_len + 3) >> 2;
              phase      = (skip_words == 0) ? PH_TOKEN : PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (skip_words > 0) skip_words--;
            if (skip_words == 0) phase = PH_TOKEN;
          end
          default: phase = PH_DONE;
        endcase
        // running off the end of the address space overrides the event
        if (64'(word_idx) >= MAX_WORD && phase != PH_DONE) begin
          r     = '0;
          r.ev  = EV_RANGE;
          phase = PH_DONE;
        end
      end
      if (phase != PH_DONE) word_idx = word_idx + 1'b1;
      if (r.ev != EV_BEGIN && r.ev != EV_PROP) r.node = '0;
      return r;
    endfunction

    function void note_word(bit [31:0] w, bit first);
      expected_q.push_back(decode_word(w, first));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 30) $display("MISMATCH %0t: %s", $realtime, what);
    endtask

    task check_event(logic [3:0] ev, logic [OFB-1:0] node, logic [OFB-1:0] pname,
                     logic [OFB-1:0] voff, logic [OFB-1:0] vlen);
      dt_event_t exp;
      beat_no++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("beat %0d unexpected, event %0h", beat_no, ev));
        return;
      end
      exp = expected_q.pop_front();
      if (ev !== exp.ev)
        report_mismatch($sformatf("beat %0d event %0h exp %0h", beat_no, ev, exp.ev));
      if (node !== exp.node)
        report_mismatch($sformatf("beat %0d node_offset %0h exp %0h",
                                  beat_no, node, exp.node));
      if (pname !== exp.pname)
        report_mismatch($sformatf("beat %0d prop_name_offset %0h exp %0h",
                                  beat_no, pname, exp.pname));
      if (voff !== exp.voff)
        report_mismatch($sformatf("beat %0d value_offset %0h exp %0h",
                                  beat_no, voff, exp.voff));
      if (vlen !== exp.vlen)
        report_mismatch($sformatf("beat %0d value_length %0h exp %0h",
                                  beat_no, vlen, exp.vlen));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  dtbp_in_if                     in_ch ();
  dtbp_out_if #(.OFFSET_BITS(OFB)) out_ch ();

  devicetree_blob_token_parser #(.OFFSET_BITS(OFB)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  dt_event_scoreboard sb = new();
  bit                 no_idle = 1'b0;
  int                 words_sent = 0;
  int                 quiet_cycles = 0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit [31:0] nonzero_word();
    return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
            8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
  endfunction

  task automatic send_word(input bit [31:0] w, input bit first);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.blob_word  <= w;
    in_ch.first_word <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(w, first);
    words_sent++;
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // header, filler up to the structure block, then a token stream; now and then a random first word instead
  task automatic send_blob();
    int unsigned r, n_fill, n_tok, kind, nw, zb;
    bit [31:0]   struct_w, strings_w, len, nm;
    no_idle = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 19) == 0) begin
      send_word($urandom, 1'b1);
      repeat ($urandom_range(0, 3)) send_word($urandom, 1'b0);
      return;
    end
    send_word(DT_MAGIC, 1'b1);
    send_word($urandom, 1'b0);
    r = $urandom_range(0, 99);
    if (r < 85)      struct_w = 16 + 4 * $urandom_range(0, 5) + $urandom_range(0, 3);
    else if (r < 92) struct_w = $urandom | 32'h0010_0000;
    else             struct_w = $urandom_range(0, 15);
    r = $urandom_range(0, 99);
    if (r < 90)      strings_w = $urandom_range(0, 'h3FFF);
    else if (r < 95) strings_w = $urandom_range('hFFF00, 'hFFFFF);
    else             strings_w = $urandom | 32'h0010_0000;
    send_word(struct_w, 1'b0);
    send_word(strings_w, 1'b0);
    if (sb.phase != PH_DONE) begin
      n_fill = ((struct_w & ~32'h3) - MIN_STRUCT_OFF) >> 2;
      repeat (n_fill) send_word($urandom, 1'b0);
      n_tok = $urandom_range(1, 14);
      repeat (n_tok) begin
        if (sb.phase == PH_DONE) break;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          send_word(TOK_BEGIN_NODE, 1'b0);
          nw = $urandom_range(1, 3);
          repeat (nw - 1) send_word(nonzero_word(), 1'b0);
          nm = $urandom_range(0, 3) == 0 ? $urandom : nonzero_word();
          zb = $urandom_range(0, 3);
          nm[zb*8 +: 8] = 8'h00;
          send_word(nm, 1'b0);
        end else if (kind < 65) begin
          r = $urandom_range(0, 99);
          if (r < 80)      len = $urandom_range(0, 12);
          else if (r < 93) len = $urandom_range(13, 40);
          else             len = $urandom | 32'h0010_0000;
          send_word(TOK_PROP, 1'b0);
          send_word(len, 1'b0);
          send_word($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 'hFFF), 1'b0);
          if (sb.phase == PH_SKIP)
            repeat (sb.skip_words) send_word($urandom, 1'b0);
        end else if (kind < 80) begin
          send_word(TOK_NOP, 1'b0);
        end else if (kind < 92) begin
          send_word(TOK_END_NODE, 1'b0);
        end else if (kind < 96) begin
          send_word($urandom, 1'b0);
        end else begin
          // cut short: the next blob restarts mid-parse
          return;
        end
      end
      if (sb.phase != PH_DONE && $urandom_range(0, 99) < 85) send_word(TOK_END, 1'b0);
    end
    repeat ($urandom_range(0, 2)) send_word($urandom, 1'b0);
  endtask

  initial begin : result_sink
    int stall;
    stall        = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_event(out_ch.event_res, out_ch.node_offset, out_ch.prop_name_offset,
                       out_ch.value_offset, out_ch.value_length);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("devicetree_blob_token_parser test failed");
      $finish;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int target;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.blob_word  <= '0;
    in_ch.first_word <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // idle word, aligned-down structure offset, every token, then header errors
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(DT_MAGIC, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0013, 1'b0);
    send_word(32'h0000_0100, 1'b0);
    send_word(TOK_NOP, 1'b0);
    send_word(TOK_BEGIN_NODE, 1'b0);
    send_word(32'h2F00_0000, 1'b0);
    send_word(TOK_PROP, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'h000F_FEFF, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h9ABC_DEF0, 1'b0);
    send_word(TOK_PROP, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(32'd0, 1'b0);
    send_word(TOK_END_NODE, 1'b0);
    send_word(TOK_END, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b1);
    send_word(DT_MAGIC, 1'b1);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    wait_results();

    target = words_sent + RAND_WORDS;
    while (words_sent < target) begin
      send_blob();
      if ($urandom_range(0, 9) == 0) wait_results();
    end
    no_idle = 1'b0;
    wait_results();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("devicetree_blob_token_parser test passed");
    end else begin
      $display("devicetree_blob_token_parser test failed");
    end
    $finish;
  end

endmodule
